// ===== hdl/button_release_and_autorepeat_core_macros.svh =====
// Assertion macros shared by the button core modules.
`ifndef BUTTON_RELEASE_AND_AUTOREPEAT_CORE_MACROS_SVH
`define BUTTON_RELEASE_AND_AUTOREPEAT_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bra_pkg.sv =====
package bra_pkg;

	// Counter and repeat level widths
	localparam int CNT_W = 16;
	localparam int LVL_W = 5;
	localparam int STEP_W = 3;

	// Repeat level bands and the weight added per held tick in each
	localparam logic [LVL_W-1:0] LEVEL_MAX = LVL_W'(20);
	localparam logic [LVL_W-1:0] LEVEL_MID = LVL_W'(10);
	localparam logic [STEP_W-1:0] STEP_FAST = STEP_W'(4);
	localparam logic [STEP_W-1:0] STEP_MID = STEP_W'(2);
	localparam logic [STEP_W-1:0] STEP_SLOW = STEP_W'(1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IDLE_LEVEL  = 2'd0,
		CFG_RELEASE_THR = 2'd1,
		CFG_REPEAT_THR  = 2'd2
	} cfg_idx_t;

	// Settings seen by the detectors
	typedef struct packed {
		logic             idle_level;
		logic [CNT_W-1:0] release_thr;
		logic [CNT_W-1:0] repeat_thr;
	} cfg_t;

	// Result flags of one tick
	typedef struct packed {
		logic release_press;
		logic repeat_press;
		logic any_press;
	} flags_t;

	// Clamp a one-bit-grown count into [lo, hi]
	function automatic logic [CNT_W-1:0] clamp_count(
		input logic [CNT_W:0]   v,
		input logic [CNT_W-1:0] lo,
		input logic [CNT_W-1:0] hi
	);
		logic [CNT_W-1:0] r;
		if (v < {1'b0, lo}) begin
			r = lo;
		end else if (v > {1'b0, hi}) begin
			r = hi;
		end else begin
			r = v[CNT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/bra_cfg.sv =====
module bra_cfg #(
	parameter int MIN_COUNT = 0,
	parameter int MAX_COUNT = 60000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [bra_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [bra_pkg::CNT_W-1:0]     wr_data,
	output bra_pkg::cfg_t                 cfg
);
	import bra_pkg::*;

	localparam logic [CNT_W-1:0] MinCnt = CNT_W'(MIN_COUNT);
	localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_COUNT);

	cfg_t cfg_q;
	logic [CNT_W-1:0] thr_clamped;

	// Thresholds are clamped into the count range on write
	assign thr_clamped = clamp_count({1'b0, wr_data}, MinCnt, MaxCnt);

	// Register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_level  <= 1'b0;
			cfg_q.release_thr <= MinCnt;
			cfg_q.repeat_thr  <= MinCnt;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_IDLE_LEVEL:  cfg_q.idle_level  <= wr_data[0];
				CFG_RELEASE_THR: cfg_q.release_thr <= thr_clamped;
				CFG_REPEAT_THR:  cfg_q.repeat_thr  <= thr_clamped;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/bra_det.sv =====
`include "button_release_and_autorepeat_core_macros.svh"

module bra_det #(
	parameter int MIN_COUNT = 0,
	parameter int MAX_COUNT = 60000
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  logic           pin,
	input  bra_pkg::cfg_t  cfg,
	output bra_pkg::flags_t flags
);
	import bra_pkg::*;

	localparam logic [CNT_W-1:0] MinCnt = CNT_W'(MIN_COUNT);
	localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_COUNT);

	logic [CNT_W-1:0] hold_ticks_q;
	logic [CNT_W-1:0] repeat_ticks_q;
	logic [LVL_W-1:0] repeat_level_q;

	logic             idle;
	logic [STEP_W-1:0] step;
	logic [CNT_W-1:0] hold_inc;
	logic [CNT_W-1:0] repeat_inc;
	logic             rel_hit;
	logic             rep_hit;
	logic [CNT_W-1:0] hold_nxt;
	logic [CNT_W-1:0] repeat_nxt;
	logic [LVL_W-1:0] level_nxt;

	assign idle = (pin == cfg.idle_level);

	// Weight per held tick from the repeat level band
	always_comb begin
		if (repeat_level_q >= LEVEL_MAX) begin
			step = STEP_FAST;
		end else if (repeat_level_q >= LEVEL_MID) begin
			step = STEP_MID;
		end else begin
			step = STEP_SLOW;
		end
	end

	// Saturating increments
	assign hold_inc   = clamp_count({1'b0, hold_ticks_q} + (CNT_W+1)'(1), MinCnt, MaxCnt);
	assign repeat_inc = clamp_count({1'b0, repeat_ticks_q} + (CNT_W+1)'(step), MinCnt, MaxCnt);

	assign rel_hit = idle && (hold_ticks_q >= cfg.release_thr);
	assign rep_hit = !idle && (repeat_inc >= cfg.repeat_thr);

	// Next state of both detectors
	always_comb begin
		if (idle) begin
			hold_nxt   = MinCnt;
			repeat_nxt = MinCnt;
			level_nxt  = '0;
		end else begin
			hold_nxt   = hold_inc;
			repeat_nxt = rep_hit ? MinCnt : repeat_inc;
			level_nxt  = (rep_hit && (repeat_level_q < LEVEL_MAX)) ?
				repeat_level_q + LVL_W'(1) : repeat_level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q   <= '0;
			repeat_ticks_q <= '0;
			repeat_level_q <= '0;
		end else if (step_en) begin
			hold_ticks_q   <= hold_nxt;
			repeat_ticks_q <= repeat_nxt;
			repeat_level_q <= level_nxt;
		end
	end

	// Flags for this tick
	assign flags.release_press = rel_hit;
	assign flags.repeat_press  = rep_hit;
	assign flags.any_press     = rel_hit | rep_hit;

	`BRA_ASSERT_NOW(a_level_cap, clk, arst_n, 1'b1, repeat_level_q <= LEVEL_MAX,
		"repeat level above cap")
	`BRA_ASSERT_NEXT(a_idle_clears, clk, arst_n, step_en && idle,
		repeat_level_q == '0 && repeat_ticks_q == MinCnt && hold_ticks_q == MinCnt,
		"idle tick did not clear counters")
	`BRA_ASSERT_NEXT(a_repeat_restart, clk, arst_n, step_en && rep_hit,
		repeat_ticks_q == MinCnt, "repeat fired without restarting count")

endmodule

// ===== hdl/button_release_and_autorepeat_core.sv =====
// Channel | Signals                                     | Direction
// --------+---------------------------------------------+----------
// input   | in_valid, in_stall, pin_level               | sample in
// output  | out_valid, out_stall, release_press,        | flags out
//         | repeat_press, any_press                     |
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data   | write in
//
// One sample per cycle while out_stall is not holding the pipeline: a sample waits in the
// input register, then the detectors update and the flags land in the result register.
// Reset clears counters, repeat level, settings and both pipeline valids.
// A stalled result blocks the input only when the input register is also full.
`include "button_release_and_autorepeat_core_macros.svh"

module button_release_and_autorepeat_core #(
	parameter int MIN_COUNT = 0,
	parameter int MAX_COUNT = 60000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          pin_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          release_press,
	output logic                          repeat_press,
	output logic                          any_press,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bra_pkg::CNT_W-1:0]     cfg_data
);
	import bra_pkg::*;

	cfg_t   cfg;
	flags_t flags;
	flags_t result_q;
	logic   valid_s1;
	logic   pin_s1;
	logic   out_valid_q;
	logic   out_free;
	logic   advance;
	logic   in_take;

	// Config writes are always taken
	assign cfg_ready = 1'b1;

	bra_cfg #(
		.MIN_COUNT(MIN_COUNT),
		.MAX_COUNT(MAX_COUNT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// Pipeline flow control
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pin_s1 <= pin_level;
		end
	end

	bra_det #(
		.MIN_COUNT(MIN_COUNT),
		.MAX_COUNT(MAX_COUNT)
	) u_det (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(advance),
		.pin    (pin_s1),
		.cfg    (cfg),
		.flags  (flags)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= flags;
		end
	end

	assign out_valid     = out_valid_q;
	assign release_press = result_q.release_press;
	assign repeat_press  = result_q.repeat_press;
	assign any_press     = result_q.any_press;

	`BRA_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall, valid_s1 && out_valid_q,
		"input stalled with a free pipeline slot")
	`BRA_ASSERT_NEXT(a_result_from_s1, clk, arst_n, !out_valid_q && !valid_s1,
		!out_valid_q, "result appeared without a staged sample")
	`BRA_ASSERT_NOW(a_any_or, clk, arst_n, out_valid_q,
		result_q.any_press == (result_q.release_press | result_q.repeat_press),
		"any_press is not the OR of both flags")

endmodule

// ===== test/button_release_and_autorepeat_core_test.sv =====
`timescale 1ns / 1ps

module button_release_and_autorepeat_core_test;

	import bra_pkg::*;

	localparam int MIN_COUNT = 0;
	localparam int MAX_COUNT = 60000;
	// Index past the last register, writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int TIMEOUT_NS = 2_000_000;
	localparam int SETTLE_CYCLES = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 pin_level = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 release_press;
	logic                 repeat_press;
	logic                 any_press;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data = '0;

	// Predictor settings and counters, at their reset values
	logic             idle_pin = 1'b0;
	logic [CNT_W-1:0] press_thr = '0;
	logic [CNT_W-1:0] rpt_thr = '0;
	logic [CNT_W-1:0] held_count = '0;
	logic [CNT_W-1:0] rpt_count = '0;
	logic [LVL_W-1:0] rpt_level = '0;

	flags_t pending_flags[$];
	int     fail_count = 0;
	bit     calm = 1'b0;
	int     hold_off_cycles = 0;

	button_release_and_autorepeat_core #(
		.MIN_COUNT(MIN_COUNT),
		.MAX_COUNT(MAX_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.release_press(release_press),
		.repeat_press(repeat_press),
		.any_press(any_press),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

	// Saturate a grown count into [MIN_COUNT, MAX_COUNT]
	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W:0] v);
		if (v < MIN_COUNT)
			return CNT_W'(MIN_COUNT);
		if (v > MAX_COUNT)
			return CNT_W'(MAX_COUNT);
		return v[CNT_W-1:0];
	endfunction

	// Advance both detectors by one pin sample and return the flags it raises
	function automatic flags_t next_flags(input logic pin);
		flags_t           f;
		logic [STEP_W-1:0] weight;
		f = '0;
		if (pin == idle_pin) begin
			if (held_count >= press_thr)
				f.release_press = 1'b1;
			held_count = CNT_W'(MIN_COUNT);
			rpt_count = CNT_W'(MIN_COUNT);
			rpt_level = '0;
		end else begin
			held_count = sat_count({1'b0, held_count} + 1'b1);
			if (rpt_level >= LEVEL_MAX)
				weight = STEP_FAST;
			else if (rpt_level >= LEVEL_MID)
				weight = STEP_MID;
			else
				weight = STEP_SLOW;
			rpt_count = sat_count({1'b0, rpt_count} + weight);
			if (rpt_count >= rpt_thr) begin
				if (rpt_level < LEVEL_MAX)
					rpt_level = rpt_level + 1'b1;
				rpt_count = CNT_W'(MIN_COUNT);
				f.repeat_press = 1'b1;
			end
		end
		f.any_press = f.release_press | f.repeat_press;
		return f;
	endfunction

	// One pin sample transaction, with random idle cycles ahead of it unless calm is set
	task automatic send_pin(input logic pin);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(99) < 33) begin
				in_valid = 1'b0;
				pin_level = 1'($urandom_range(1));
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		pin_level = pin;
		do
			@(posedge clk);
		while (in_stall);
		pending_flags.push_back(next_flags(pin));
	endtask

	task automatic send_run(input logic pin, input int count);
		repeat (count)
			send_pin(pin);
	endtask

	// Stop sending and wait until every expected result has come back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_flags.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_IDLE_LEVEL: idle_pin = data[0];
			CFG_RELEASE_THR: press_thr = sat_count({1'b0, data});
			CFG_REPEAT_THR: rpt_thr = sat_count({1'b0, data});
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Receiver: random stalls, none while calm, or a forced hold-off counted down here
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall = 1'b1;
			hold_off_cycles = hold_off_cycles - 1;
		end else if (calm) begin
			out_stall = 1'b0;
		end else begin
			out_stall = ($urandom_range(99) < 33);
		end
	end

	task automatic log_mismatch(input string what, input flags_t want);
		if (fail_count < 10)
			$display("%0t: %s: expected rel=%b rpt=%b any=%b, got rel=%b rpt=%b any=%b",
				$realtime, what, want.release_press, want.repeat_press, want.any_press,
				release_press, repeat_press, any_press);
		fail_count++;
	endtask

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_flags
		flags_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_flags.size() == 0) begin
				log_mismatch("unexpected result", '0);
			end else begin
				want = pending_flags.pop_front();
				if (release_press !== want.release_press || repeat_press !== want.repeat_press ||
						any_press !== want.any_press)
					log_mismatch("flag mismatch", want);
			end
		end
	end

	// Reset settings: idle reports a press every tick, held fires a repeat every tick
	task automatic test_defaults_after_reset();
		send_pin(1'b0);
		send_pin(1'b0);
		send_run(1'b1, 3);
		send_pin(1'b0);
		send_pin(1'b0);
	endtask

	// Register extremes, ignored index, small thresholds around the press boundary
	task automatic test_register_extremes();
		write_reg(CFG_IDLE_LEVEL, 16'hFFFF);
		write_reg(CFG_RELEASE_THR, 16'hFFFF);
		write_reg(CFG_REPEAT_THR, 16'h0000);
		write_reg(CFG_SPARE, 16'($urandom_range(16'hFFFF)));
		send_pin(1'b1);
		send_run(1'b0, 2);
		send_pin(1'b1);
		write_reg(CFG_RELEASE_THR, 16'h0001);
		write_reg(CFG_REPEAT_THR, 16'h0001);
		send_run(1'b0, 2);
		send_run(1'b1, 2);
		write_reg(CFG_RELEASE_THR, 16'h0003);
		write_reg(CFG_REPEAT_THR, 16'h0004);
		send_run(1'b0, 2);
		send_pin(1'b1);
		send_run(1'b0, 3);
		send_run(1'b1, 2);
	endtask

	// Long hold so the repeat weight climbs through all three bands
	task automatic test_acceleration();
		write_reg(CFG_IDLE_LEVEL, 16'h0000);
		write_reg(CFG_RELEASE_THR, 16'h0005);
		write_reg(CFG_REPEAT_THR, 16'h0004);
		send_run(1'b1, 150);
		send_run(1'b0, 2);
	endtask

	// Long hold under the clamped top thresholds: no press and no repeat fires
	task automatic test_high_thresholds();
		calm = 1'b1;
		write_reg(CFG_RELEASE_THR, 16'hFFFF);
		write_reg(CFG_REPEAT_THR, 16'hFFFF);
		send_run(1'b1, 150);
		send_pin(1'b0);
		send_run(1'b1, 10);
		send_pin(1'b0);
		drain();
		calm = 1'b0;
	endtask

	// Receiver holds off while items keep coming, then sender waits for all results
	task automatic test_backpressure();
		write_reg(CFG_RELEASE_THR, 16'h0002);
		write_reg(CFG_REPEAT_THR, 16'h0003);
		hold_off_cycles = 300;
		repeat (40)
			send_pin(1'($urandom_range(1)));
		drain();
		repeat (20)
			send_pin(1'($urandom_range(1)));
		drain();
	endtask

	function automatic logic [CNT_W-1:0] pick_threshold();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(16'hFFFF));
			default: return 16'($urandom_range(2, 30));
		endcase
	endfunction

	// Random settings per phase; mostly press/release sequences, some noise
	task automatic test_random_phases();
		int sent;
		int len;
		for (int phase = 0; phase < 8; phase++) begin
			calm = (phase == 3);
			write_reg(CFG_IDLE_LEVEL, 16'($urandom_range(16'hFFFF)));
			write_reg(CFG_RELEASE_THR, pick_threshold());
			write_reg(CFG_REPEAT_THR, pick_threshold());
			if ($urandom_range(3) == 0)
				write_reg(CFG_SPARE, 16'($urandom_range(16'hFFFF)));
			sent = 0;
			while (sent < 40) begin
				if ($urandom_range(99) < 80) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
					send_run(~idle_pin, len);
					sent += len;
					len = $urandom_range(1, 4);
					send_run(idle_pin, len);
					sent += len;
				end else begin
					len = $urandom_range(1, 8);
					repeat (len)
						send_pin(1'($urandom_range(1)));
					sent += len;
				end
			end
			drain();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults_after_reset();
		test_register_extremes();
		test_acceleration();
		test_high_thresholds();
		test_backpressure();
		test_random_phases();

		drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (fail_count == 0 && pending_flags.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
